/* hdl/etsu_pkg.sv */
// ----------------------------------------------------------------------------
// etsu_pkg
// Shared types, codes and character helpers for the expression token scanner.
// ----------------------------------------------------------------------------
package etsu_pkg;

   localparam int POS_BITS    = 16;   // width of the running character offset
   localparam int FIELD_BITS  = 16;
   localparam int KIND_BITS   = 4;
   localparam int QUEUE_DEPTH = 4;    // power of two, at least 2
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UN    = 8'h4E;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_UO    = 8'h4F;
   localparam logic [7:0] CH_UR    = 8'h52;
   localparam logic [7:0] CASE_GAP = 8'h20;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NUM    = 4'd0,
      KIND_IDENT  = 4'd1,
      KIND_AND    = 4'd2,
      KIND_OR     = 4'd3,
      KIND_GT     = 4'd4,
      KIND_GTE    = 4'd5,
      KIND_LT     = 4'd6,
      KIND_LTE    = 4'd7,
      KIND_EQ     = 4'd8,
      KIND_NEQ    = 4'd9,
      KIND_LPAREN = 4'd10,
      KIND_RPAREN = 4'd11,
      KIND_EOF    = 4'd12
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_NUM   = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_GT    = 3'd3,
      MODE_LT    = 3'd4,
      MODE_EQ    = 3'd5,
      MODE_BANG  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      KW_EMPTY = 3'd0,
      KW_A     = 3'd1,
      KW_AN    = 3'd2,
      KW_AND   = 3'd3,
      KW_O     = 3'd4,
      KW_OR    = 3'd5,
      KW_NONE  = 3'd6
   } kw_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic                  last;
   } token_type;

   // up to two tokens per item, packed to the front
   typedef struct packed {
      logic [1:0] count;
      token_type  slot0;
      token_type  slot1;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic kw_type kw_next(input kw_type kw, input logic [7:0] c);
      logic [7:0] u;
      kw_type     nxt;
      u   = ((c >= CH_LA) && (c <= CH_LZ)) ? c - CASE_GAP : c;
      nxt = KW_NONE;
      unique case (kw)
         KW_EMPTY: begin
            if (u == CH_UA) nxt = KW_A;
            else if (u == CH_UO) nxt = KW_O;
         end
         KW_A:  if (u == CH_UN) nxt = KW_AN;
         KW_AN: if (u == CH_UD) nxt = KW_AND;
         KW_O:  if (u == CH_UR) nxt = KW_OR;
         default: nxt = KW_NONE;
      endcase
      return nxt;
   endfunction

endpackage

/* hdl/etsu_if.sv */
// ----------------------------------------------------------------------------
// etsu_req_if / etsu_rsp_if
// Valid/ready channels for characters in and tokens out.
// ----------------------------------------------------------------------------
interface etsu_req_if;
   import etsu_pkg::*;

   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface etsu_rsp_if;
   import etsu_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  token_kind;
   logic [FIELD_BITS-1:0] token_start;
   logic [FIELD_BITS-1:0] token_length;
   logic                  last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input last_of_run, output ready);
endinterface

/* hdl/expression_token_scanner_unit.sv */
// Path: a token is written into the token queue, then moved to the output register.
// Throughput: one item per cycle while the queue has room; the output
// register drains one token per cycle while rsp is ready, so a two-token item
// uses rsp twice, and req stalls when the four-entry queue lacks room for two more.
// Reset: synchronous, active high; clears the scan state, offset, queue and
// output valid. No clearing pass.
// ----------------------------------------------------------------------------
// expression_token_scanner_unit
// Lexer for comparison expressions: characters in, (kind, start, length) out.
// ----------------------------------------------------------------------------
module expression_token_scanner_unit (
   input  logic      clock,
   input  logic      reset,
   etsu_req_if.sink  req,
   etsu_rsp_if.source rsp
);
   import etsu_pkg::*;

   push_type  push;
   token_type head;
   logic      not_empty;
   logic      space_ok;
   logic      pop;

   etsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .space_ok (space_ok),
      .push     (push)
   );

   etsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .space_ok  (space_ok)
   );

   etsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // an end item always queues eof as its final token
   a_end_gives_eof: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.req_type == REQ_END)) |->
         (((push.count == 2'd1) && (push.slot0.kind == KIND_EOF)) ||
          ((push.count == 2'd2) && (push.slot1.kind == KIND_EOF))))
      else $error("end item did not queue eof");

   // exactly the final queued token of an item carries last
   a_last_marks_final: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |->
         (((push.count == 2'd1) && push.slot0.last) ||
          ((push.count == 2'd2) && !push.slot0.last && push.slot1.last)))
      else $error("last flag misplaced in queued tokens");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.token_kind == KIND_EOF)) |->
         ((rsp.token_length == '0) && rsp.last_of_run))
      else $error("eof token with length or without last");

   // nothing is queued while the front reports no room
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !space_ok |-> (push.count == 2'd0))
      else $error("token queue overflow");
`endif

endmodule

/* hdl/etsu_front.sv */
// ----------------------------------------------------------------------------
// etsu_front
// Accepts characters, runs the scan state machine and produces up to two
// tokens per item for the token queue.
// ----------------------------------------------------------------------------
module etsu_front (
   input  logic              clock,
   input  logic              reset,
   etsu_req_if.sink          req,
   input  logic              space_ok,
   output etsu_pkg::push_type push
);
   import etsu_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [FIELD_BITS-1:0]   pend_start_ff, pend_start_in;
   logic [FIELD_BITS-1:0]   pend_len_ff, pend_len_in;
   kw_type                  kw_ff, kw_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;

   logic                    accept;
   logic [7:0]              c;
   logic [32:0]             pos_wide;
   logic [FIELD_BITS-1:0]   pos16;
   logic                    cont;
   logic                    pair;
   mode_type                fresh_mode;
   logic                    flush_valid;
   token_type               flush_tok;
   logic                    tail_valid;
   token_type               tail_tok;

   assign req.ready = space_ok;
   assign accept    = req.valid && space_ok;
   assign c         = req.char_code;

   assign pos_wide = 33'(pos_ff);
   assign pos16    = (pos_wide > 33'(FIELD_MAX)) ? FIELD_MAX : pos_wide[FIELD_BITS-1:0];

   // number or identifier keeps growing
   assign cont = ((mode_ff == MODE_NUM) && (is_digit(c) || (c == CH_DOT))) ||
                 ((mode_ff == MODE_IDENT) &&
                  (is_letter(c) || is_digit(c) || (c == CH_UNDER)));
   assign pair = ((mode_ff == MODE_GT) || (mode_ff == MODE_LT) ||
                  (mode_ff == MODE_EQ) || (mode_ff == MODE_BANG)) && (c == CH_EQ);

   always_comb begin
      fresh_mode = MODE_IDLE;
      if (is_digit(c)) fresh_mode = MODE_NUM;
      else if (is_letter(c)) fresh_mode = MODE_IDENT;
      else if (c == CH_GT) fresh_mode = MODE_GT;
      else if (c == CH_LT) fresh_mode = MODE_LT;
      else if (c == CH_EQ) fresh_mode = MODE_EQ;
      else if (c == CH_BANG) fresh_mode = MODE_BANG;
   end

   // next state
   always_comb begin
      mode_in       = mode_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      kw_in         = kw_ff;
      pos_in        = pos_ff;
      if (accept) begin
         if (req.req_type == REQ_END) begin
            mode_in       = MODE_IDLE;
            pend_start_in = '0;
            pend_len_in   = '0;
            kw_in         = KW_EMPTY;
            pos_in        = '0;
         end else begin
            if (cont) begin
               if (pend_len_ff != FIELD_MAX) pend_len_in = pend_len_ff + FIELD_BITS'(1);
               if (mode_ff == MODE_IDENT) kw_in = kw_next(kw_ff, c);
            end else if (pair) begin
               mode_in = MODE_IDLE;
            end else if ((mode_ff != MODE_IDLE) || !is_space(c)) begin
               mode_in       = fresh_mode;
               pend_start_in = pos16;
               pend_len_in   = FIELD_BITS'(1);
               if (is_letter(c)) kw_in = kw_next(KW_EMPTY, c);
            end
            if (pos_ff != {POS_BITS{1'b1}}) pos_in = pos_ff + POS_BITS'(1);
         end
      end
   end

   // token outputs
   always_comb begin
      flush_valid      = 1'b0;
      flush_tok.kind   = KIND_NUM;
      flush_tok.start  = pend_start_ff;
      flush_tok.length = FIELD_BITS'(1);
      flush_tok.last   = 1'b0;
      unique case (mode_ff)
         MODE_NUM: begin
            flush_valid      = 1'b1;
            flush_tok.length = pend_len_ff;
         end
         MODE_IDENT: begin
            flush_valid      = 1'b1;
            flush_tok.length = pend_len_ff;
            flush_tok.kind   = (kw_ff == KW_AND) ? KIND_AND :
                               ((kw_ff == KW_OR) ? KIND_OR : KIND_IDENT);
         end
         MODE_GT: begin
            flush_valid    = 1'b1;
            flush_tok.kind = KIND_GT;
         end
         MODE_LT: begin
            flush_valid    = 1'b1;
            flush_tok.kind = KIND_LT;
         end
         default: flush_valid = 1'b0;
      endcase

      tail_valid      = 1'b0;
      tail_tok.kind   = KIND_EOF;
      tail_tok.start  = pos16;
      tail_tok.length = '0;
      tail_tok.last   = 1'b0;

      if (req.req_type == REQ_END) begin
         tail_valid = 1'b1;
      end else if (cont) begin
         flush_valid = 1'b0;
      end else if (pair) begin
         // the pair replaces the flush token
         tail_valid      = 1'b1;
         flush_valid     = 1'b0;
         tail_tok.start  = pend_start_ff;
         tail_tok.length = FIELD_BITS'(2);
         unique case (mode_ff)
            MODE_GT: tail_tok.kind = KIND_GTE;
            MODE_LT: tail_tok.kind = KIND_LTE;
            MODE_EQ: tail_tok.kind = KIND_EQ;
            default: tail_tok.kind = KIND_NEQ;
         endcase
      end else begin
         tail_valid      = (c == CH_LPAR) || (c == CH_RPAR);
         tail_tok.length = FIELD_BITS'(1);
         tail_tok.kind   = (c == CH_LPAR) ? KIND_LPAREN : KIND_RPAREN;
      end

      push.slot0 = flush_tok;
      push.slot1 = tail_tok;
      if (!accept) begin
         push.count = 2'd0;
      end else if (flush_valid && tail_valid) begin
         push.count      = 2'd2;
         push.slot1.last = 1'b1;
      end else if (flush_valid) begin
         push.count      = 2'd1;
         push.slot0.last = 1'b1;
      end else if (tail_valid) begin
         push.count      = 2'd1;
         push.slot0      = tail_tok;
         push.slot0.last = 1'b1;
      end else begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pend_start_ff <= '0;
         pend_len_ff   <= '0;
         kw_ff         <= KW_EMPTY;
         pos_ff        <= '0;
      end else begin
         mode_ff       <= mode_in;
         pend_start_ff <= pend_start_in;
         pend_len_ff   <= pend_len_in;
         kw_ff         <= kw_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

/* hdl/etsu_queue.sv */
// ----------------------------------------------------------------------------
// etsu_queue
// Small token queue: two writes and one read per cycle.
// ----------------------------------------------------------------------------
module etsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  etsu_pkg::push_type push,
   input  logic               pop,
   output etsu_pkg::token_type head,
   output logic               not_empty,
   output logic               space_ok
);
   import etsu_pkg::*;

   token_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QPTR_BITS-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + QPTR_BITS'(1);
   assign head        = entries_ff[rd_ptr_ff];
   assign not_empty   = (count_ff != '0);
   // room for a full two-token item
   assign space_ok    = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign count_in  = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wr_ptr_ff] <= push.slot0;
      if (push.count == 2'd2) entries_ff[wr_ptr_next] <= push.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/etsu_back.sv */
// ----------------------------------------------------------------------------
// etsu_back
// Output register: takes one token a cycle from the queue when it is empty or
// being read, and holds it on the response channel until it is taken.
// ----------------------------------------------------------------------------
module etsu_back (
   input  logic                clock,
   input  logic                reset,
   input  etsu_pkg::token_type head,
   input  logic                not_empty,
   output logic                pop,
   etsu_rsp_if.source          rsp
);
   import etsu_pkg::*;

   logic      valid_ff, valid_in;
   token_type tok_ff, tok_in;

   assign pop      = not_empty && (!valid_ff || rsp.ready);
   assign valid_in = pop ? 1'b1 : (valid_ff && !rsp.ready);
   assign tok_in   = pop ? head : tok_ff;

   assign rsp.valid        = valid_ff;
   assign rsp.token_kind   = tok_ff.kind;
   assign rsp.token_start  = tok_ff.start;
   assign rsp.token_length = tok_ff.length;
   assign rsp.last_of_run  = tok_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

endmodule

/* bench/tb_expression_token_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_token_scanner_unit
// Self-checking bench for the token scanner. A directed table covers every
// token kind and the lone '=' / '!' drops. A long identifier stretches the
// length to 48 characters. Random expression text follows, with stalls on both
// channels. Each token is checked against a local lexer mirror or its typed row.
// ----------------------------------------------------------------------------
module tb_expression_token_scanner_unit;
   import etsu_pkg::*;

   localparam int                 CLK_HALF        = 4;
   localparam int                 RESET_CYCLES    = 9;
   localparam int                 RANDOM_ITEMS    = 870;
   localparam int                 LONG_IDENT_LEN  = 48;
   localparam int                 HOLD_CYCLES     = 40;
   localparam int                 DRAIN_CYCLES    = 8;
   localparam int                 WATCHDOG_CYCLES = 1000;
   localparam longint unsigned    POS_TOP         = (64'd1 << POS_BITS) - 1;

   typedef struct packed {
      logic       is_end;
      logic [7:0] code;
   } scan_item_type;

   typedef struct packed {
      logic       is_end;
      logic [7:0] code;
      logic       typed;
      token_type  tok;
   } plan_row_type;

   logic clock;
   logic reset;

   etsu_req_if req_ch ();
   etsu_rsp_if rsp_ch ();

   expression_token_scanner_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // lexer mirror state
   mode_type         lx_mode  = MODE_IDLE;
   logic [15:0]      lx_start = '0;
   logic [15:0]      lx_len   = '0;
   kw_type           lx_kw    = KW_EMPTY;
   longint unsigned  lx_pos   = 0;

   token_type        run_buf [0:1];
   int               run_n;
   token_type        tokens_due [$];
   plan_row_type     directed_rows [$];
   scan_item_type    text_plan [$];

   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   bit               idle_on        = 1'b1;
   bit               hold_request   = 1'b0;
   bit               cur_typed      = 1'b0;
   token_type        cur_typed_tok  = '0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- lexer mirror
   function automatic bit digit_char(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic bit letter_char(input logic [7:0] c);
      return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
   endfunction

   function automatic bit blank_char(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // only called with letters, digits and underscore, so clearing the case bit
   // upper-cases letters without turning anything else into A, N, D, O or R
   function automatic kw_type kw_step(input kw_type kw, input logic [7:0] c);
      logic [7:0] up;
      kw_type     nxt;
      up  = c & ~CASE_GAP;
      nxt = KW_NONE;
      case (kw)
         KW_EMPTY: begin
            if (up == CH_UA) nxt = KW_A;
            else if (up == CH_UO) nxt = KW_O;
         end
         KW_A:  if (up == CH_UN) nxt = KW_AN;
         KW_AN: if (up == CH_UD) nxt = KW_AND;
         KW_O:  if (up == CH_UR) nxt = KW_OR;
         default: nxt = KW_NONE;
      endcase
      return nxt;
   endfunction

   function void note_token(input kind_type k, input logic [15:0] s, input logic [15:0] l);
      run_buf[run_n].kind   = k;
      run_buf[run_n].start  = s;
      run_buf[run_n].length = l;
      run_buf[run_n].last   = 1'b0;
      run_n++;
   endfunction

   task flush_pending();
      case (lx_mode)
         MODE_NUM: note_token(KIND_NUM, lx_start, lx_len);
         MODE_IDENT: begin
            if (lx_kw == KW_AND) note_token(KIND_AND, lx_start, lx_len);
            else if (lx_kw == KW_OR) note_token(KIND_OR, lx_start, lx_len);
            else note_token(KIND_IDENT, lx_start, lx_len);
         end
         MODE_GT: note_token(KIND_GT, lx_start, 16'd1);
         MODE_LT: note_token(KIND_LT, lx_start, 16'd1);
         default: ;
      endcase
      lx_mode = MODE_IDLE;
   endtask

   task start_token(input logic [7:0] c, input logic [15:0] at);
      lx_start = at;
      lx_len   = 16'd1;
      if (digit_char(c)) lx_mode = MODE_NUM;
      else if (letter_char(c)) begin
         lx_mode = MODE_IDENT;
         lx_kw   = kw_step(KW_EMPTY, c);
      end
      else if (c == CH_GT) lx_mode = MODE_GT;
      else if (c == CH_LT) lx_mode = MODE_LT;
      else if (c == CH_EQ) lx_mode = MODE_EQ;
      else if (c == CH_BANG) lx_mode = MODE_BANG;
      else if (c == CH_LPAR) note_token(KIND_LPAREN, at, 16'd1);
      else if (c == CH_RPAR) note_token(KIND_RPAREN, at, 16'd1);
   endtask

   task lex_item(input logic is_end, input logic [7:0] c);
      logic [15:0] at;
      run_n = 0;
      at    = (lx_pos > FIELD_MAX) ? FIELD_MAX : 16'(lx_pos);
      if (is_end == REQ_END) begin
         flush_pending();
         note_token(KIND_EOF, at, 16'd0);
         lx_mode  = MODE_IDLE;
         lx_start = '0;
         lx_len   = '0;
         lx_kw    = KW_EMPTY;
         lx_pos   = 0;
      end
      else begin
         case (lx_mode)
            MODE_NUM: begin
               if (digit_char(c) || c == CH_DOT) begin
                  if (lx_len < FIELD_MAX) lx_len++;
               end
               else begin
                  flush_pending();
                  start_token(c, at);
               end
            end
            MODE_IDENT: begin
               if (letter_char(c) || digit_char(c) || c == CH_UNDER) begin
                  if (lx_len < FIELD_MAX) lx_len++;
                  lx_kw = kw_step(lx_kw, c);
               end
               else begin
                  flush_pending();
                  start_token(c, at);
               end
            end
            MODE_GT, MODE_LT, MODE_EQ, MODE_BANG: begin
               if (c == CH_EQ) begin
                  case (lx_mode)
                     MODE_GT: note_token(KIND_GTE, lx_start, 16'd2);
                     MODE_LT: note_token(KIND_LTE, lx_start, 16'd2);
                     MODE_EQ: note_token(KIND_EQ, lx_start, 16'd2);
                     default: note_token(KIND_NEQ, lx_start, 16'd2);
                  endcase
                  lx_mode = MODE_IDLE;
               end
               else begin
                  // lone '=' / '!' drops here, the new byte is scanned fresh
                  flush_pending();
                  start_token(c, at);
               end
            end
            default: begin
               lx_mode = MODE_IDLE;
               if (!blank_char(c)) start_token(c, at);
            end
         endcase
         if (lx_pos < POS_TOP) lx_pos++;
      end
      if (run_n > 0) run_buf[run_n-1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      token_type due;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (tokens_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: no token due, got kind %0d start %0d length %0d last %0b",
                        $time, rsp_ch.token_kind, rsp_ch.token_start,
                        rsp_ch.token_length, rsp_ch.last_of_run);
            end
            else begin
               due = tokens_due.pop_front();
               if (rsp_ch.token_kind !== due.kind || rsp_ch.token_start !== due.start ||
                   rsp_ch.token_length !== due.length || rsp_ch.last_of_run !== due.last)
               begin
                  mismatch_count++;
                  $display({"%0t: token mismatch: expected kind %0d start %0d length %0d ",
                            "last %0b, got kind %0d start %0d length %0d last %0b"},
                           $time, due.kind, due.start, due.length, due.last,
                           rsp_ch.token_kind, rsp_ch.token_start,
                           rsp_ch.token_length, rsp_ch.last_of_run);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            lex_item(req_ch.req_type, req_ch.char_code);
            if (cur_typed) tokens_due.push_back(cur_typed_tok);
            else for (int i = 0; i < run_n; i++) tokens_due.push_back(run_buf[i]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- token sink
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end
         else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end
         else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end
         else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   // called at a falling edge, returns at the falling edge after the handshake
   task offer(input logic is_end, input logic [7:0] code, input bit typed,
              input token_type tok);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      cur_typed     = typed;
      cur_typed_tok = tok;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= is_end;
      req_ch.char_code <= code;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function void add_row(input logic is_end, input logic [7:0] code, input bit typed = 1'b0,
                         input kind_type k = KIND_EOF, input logic [15:0] s = '0,
                         input logic [15:0] l = '0);
      plan_row_type row;
      row.is_end     = is_end;
      row.code       = code;
      row.typed      = typed;
      row.tok.kind   = k;
      row.tok.start  = s;
      row.tok.length = l;
      row.tok.last   = 1'b1;
      directed_rows.push_back(row);
   endfunction

   function automatic string kw_word(input int n);
      case (n)
         0: return "and";
         1: return "AND";
         2: return "aNd";
         3: return "or";
         4: return "Or";
         5: return "an";
         6: return "o";
         7: return "andx";
         8: return "or_7";
         default: return "ANDD";
      endcase
   endfunction

   function void plan_char(input logic [7:0] c);
      scan_item_type it;
      it.is_end = REQ_CHAR;
      it.code   = c;
      text_plan.push_back(it);
   endfunction

   // one random token-shaped piece of text, mostly well formed
   function void plan_fragment();
      string         w;
      int            len;
      int            pick;
      scan_item_type it;
      pick = $urandom_range(0, 19);
      if (pick <= 3) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
         plan_char(8'(CH_0 + $urandom_range(0, 9)));
         for (int i = 1; i < len; i++)
            plan_char(($urandom_range(0, 3) == 0) ? CH_DOT :
                      8'(CH_0 + $urandom_range(0, 9)));
      end
      else if (pick <= 7) begin
         if ($urandom_range(0, 2) == 0) begin
            w = kw_word($urandom_range(0, 9));
            for (int i = 0; i < w.len(); i++) plan_char(w[i]);
         end
         else begin
            plan_char(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + $urandom_range(0, 25)));
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 3))
                  0: plan_char(8'(CH_0 + $urandom_range(0, 9)));
                  1: plan_char(CH_UNDER);
                  2: plan_char(8'(CH_UA + $urandom_range(0, 25)));
                  default: plan_char(8'(CH_LA + $urandom_range(0, 25)));
               endcase
            end
         end
      end
      else if (pick <= 11) begin
         case ($urandom_range(0, 9))
            0: plan_char(CH_GT);
            1: begin plan_char(CH_GT); plan_char(CH_EQ); end
            2: plan_char(CH_LT);
            3: begin plan_char(CH_LT); plan_char(CH_EQ); end
            4: begin plan_char(CH_EQ); plan_char(CH_EQ); end
            5: begin plan_char(CH_BANG); plan_char(CH_EQ); end
            6: plan_char(CH_LPAR);
            7: plan_char(CH_RPAR);
            8: plan_char(CH_EQ);
            default: plan_char(CH_BANG);
         endcase
      end
      else if (pick <= 14) begin
         plan_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
      end
      else if (pick <= 17) begin
         plan_char(8'($urandom_range(0, 255)));
      end
      else begin
         it.is_end = REQ_END;
         it.code   = 8'($urandom_range(0, 255));
         text_plan.push_back(it);
      end
      if (pick <= 11 && $urandom_range(0, 1) == 0)
         plan_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
   endfunction

   initial begin
      token_type     no_tok;
      scan_item_type it;
      int            sent;
      no_tok           = '0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_CHAR;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;

      // end on empty text, parens, keyword in mixed case
      add_row(REQ_END,  8'h00, 1'b1, KIND_EOF,    16'd0, 16'd0);
      add_row(REQ_CHAR, CH_LPAR, 1'b1, KIND_LPAREN, 16'd0, 16'd1);
      add_row(REQ_CHAR, CH_RPAR, 1'b1, KIND_RPAREN, 16'd1, 16'd1);
      add_row(REQ_CHAR, "a");
      add_row(REQ_CHAR, "N");
      add_row(REQ_CHAR, "d");
      add_row(REQ_CHAR, CH_SPACE, 1'b1, KIND_AND, 16'd2, 16'd3);
      // pending token flushed by a one-byte token: two tokens from one item
      add_row(REQ_CHAR, "o");
      add_row(REQ_CHAR, "R");
      add_row(REQ_CHAR, CH_LPAR);
      add_row(REQ_CHAR, "7");
      add_row(REQ_CHAR, CH_DOT);
      add_row(REQ_CHAR, CH_GT);
      add_row(REQ_CHAR, CH_EQ);
      add_row(REQ_CHAR, CH_LT);
      add_row(REQ_CHAR, "Z");
      add_row(REQ_CHAR, CH_EQ);
      add_row(REQ_CHAR, CH_EQ);
      add_row(REQ_CHAR, CH_BANG);
      add_row(REQ_CHAR, CH_EQ);
      // lone '=' before a non-ASCII byte, lone '!' before '<'
      add_row(REQ_CHAR, CH_EQ);
      add_row(REQ_CHAR, 8'hFF);
      add_row(REQ_CHAR, CH_BANG);
      add_row(REQ_CHAR, CH_LT);
      add_row(REQ_CHAR, CH_EQ);
      add_row(REQ_CHAR, CH_GT);
      add_row(REQ_END,  8'hFF);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i].is_end, directed_rows[i].code, directed_rows[i].typed,
               directed_rows[i].tok);

      // long identifier, then a delimiter pair
      for (int i = 0; i < LONG_IDENT_LEN; i++) offer(REQ_CHAR, "x", 1'b0, no_tok);
      offer(REQ_CHAR, CH_SPACE, 1'b0, no_tok);
      offer(REQ_CHAR, CH_LPAR, 1'b0, no_tok);
      offer(REQ_END, 8'h00, 1'b0, no_tok);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (text_plan.size() == 0) plan_fragment();
         it = text_plan.pop_front();
         offer(it.is_end, it.code, 1'b0, no_tok);
         sent++;
         if (sent == RANDOM_ITEMS / 3) hold_request = 1'b1;
         if (sent == 2 * RANDOM_ITEMS / 3) begin
            req_ch.valid <= 1'b0;
            while (tokens_due.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         if (sent == RANDOM_ITEMS - 150) idle_on = 1'b0;
      end
      offer(REQ_END, 8'h00, 1'b0, no_tok);
      req_ch.valid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end
      else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/etsu_pkg.sv
hdl/etsu_if.sv
hdl/etsu_front.sv
hdl/etsu_queue.sv
hdl/etsu_back.sv
hdl/expression_token_scanner_unit.sv
bench/tb_expression_token_scanner_unit.sv
